// ===== rtl/espmt_pkg.sv =====
`timescale 1ns / 1ps
package espmt_pkg;
   localparam int ENTRIES_DEF = 48;
   localparam logic [15:0] REFRESH_RST = 16'd30000;
   localparam logic [3:0] IDLE_RST = 4'd6;
   localparam logic [10:0] TEMP_SPI_BASE = 11'd1500;

   // result status codes
   localparam logic [2:0] ST_SPI_HIT = 3'd0;
   localparam logic [2:0] ST_ADDR_HIT = 3'd1;
   localparam logic [2:0] ST_NEW = 3'd2;
   localparam logic [2:0] ST_NO_HDR = 3'd3;
   localparam logic [2:0] ST_DENIED = 3'd4;
   localparam logic [2:0] ST_FULL = 3'd5;
   localparam logic [2:0] ST_TICK = 3'd6;

   // configuration register indexes
   localparam logic CSR_REFRESH = 1'b0;
   localparam logic CSR_IDLE = 1'b1;

   // how the winning cell is updated
   localparam logic [1:0] KIND_SPI = 2'd0;
   localparam logic [1:0] KIND_ADDR = 2'd1;
   localparam logic [1:0] KIND_NEW = 2'd2;

   // entry contents
   typedef struct packed {
      logic        valid;
      logic [31:0] lspi;
      logic [31:0] rspi;
      logic [31:0] laddr;
      logic [31:0] raddr;
      logic        seen;
      logic [3:0]  idle;
      logic [15:0] cnt;
   } entry_type;

   // broadcast command to every cell
   typedef struct packed {
      logic        tick;
      logic        commit;
      logic [31:0] spi;
      logic [31:0] src;
      logic [31:0] dst;
      logic        priv;
      logic [15:0] period;
      logic [3:0]  limit;
   } cmd_type;

   // per-cell match flags
   typedef struct packed {
      logic spi_hit;
      logic addr_hit;
      logic free;
   } flag_type;

   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_OUT} state_type;
endpackage

// ===== rtl/espmt_cell.sv =====
`timescale 1ns / 1ps
module espmt_cell (
   input  logic               clock,
   input  logic               reset,
   input  espmt_pkg::cmd_type cmd,
   input  logic               win,
   input  logic [1:0]         win_kind,
   output espmt_pkg::flag_type flags
);
   espmt_pkg::entry_type e_ff, e_in;
   logic hit_l, hit_r;

   // match flags against the probed packet
   always_comb begin
      hit_l = (cmd.src == e_ff.laddr) && cmd.priv;
      hit_r = (cmd.src == e_ff.raddr) && (e_ff.rspi == 32'd0);
      flags.spi_hit = e_ff.valid && ((cmd.spi == e_ff.lspi) || (cmd.spi == e_ff.rspi));
      flags.addr_hit = e_ff.valid && (hit_l || hit_r);
      flags.free = !e_ff.valid;
   end

   // entry update on tick or on packet commit
   always_comb begin
      e_in = e_ff;
      if (cmd.tick && e_ff.valid) begin
         if (e_ff.cnt > 16'd1) begin
            e_in.cnt = e_ff.cnt - 16'd1;
         end else if (e_ff.seen) begin
            e_in.seen = 1'b0;
            e_in.idle = 4'd0;
            e_in.cnt = cmd.period;
         end else begin
            e_in.idle = (e_ff.idle == 4'd15) ? 4'd15 : e_ff.idle + 4'd1;
            if (e_in.idle >= cmd.limit) e_in = '0;
            else e_in.cnt = cmd.period;
         end
      end else if (cmd.commit && win) begin
         e_in.seen = 1'b1;
         unique case (win_kind)
            espmt_pkg::KIND_SPI: begin
               if (cmd.spi == e_ff.lspi && cmd.src == e_ff.raddr) e_in.rspi = cmd.spi;
            end
            espmt_pkg::KIND_ADDR: begin
               if (hit_l) begin
                  e_in.lspi = cmd.spi;
                  if (cmd.dst != e_ff.raddr) begin
                     e_in.raddr = cmd.dst;
                     e_in.rspi = 32'd0;
                  end
               end else begin
                  e_in.rspi = cmd.spi;
               end
            end
            default: begin
               e_in = '0;
               e_in.valid = 1'b1;
               e_in.seen = 1'b1;
               e_in.lspi = cmd.spi;
               e_in.laddr = cmd.src;
               e_in.raddr = cmd.dst;
               e_in.cnt = cmd.period;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) e_ff <= '0;
      else e_ff <= e_in;
   end
endmodule

// ===== rtl/espmt_prio.sv =====
`timescale 1ns / 1ps
module espmt_prio #(
   parameter int N = espmt_pkg::ENTRIES_DEF
) (
   input  logic [N-1:0]         req,
   output logic                 any,
   output logic [$clog2(N+1)-1:0] idx
);
   // lowest set bit wins
   always_comb begin
      any = 1'b0;
      idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (req[i]) begin
            any = 1'b1;
            idx = ($clog2(N+1))'(i);
         end
      end
   end
endmodule

// ===== rtl/esp_spi_mapping_table.sv =====
`timescale 1ns / 1ps
// ESP flow mapping table.
// req_ channel: one beat per packet or timer tick.
//   req_tuser = action. req_tdata packs header_present, spi, src_ip, dst_ip,
//   from_private_iface from bit 0 up.
// rsp_ channel: exactly one beat per request: accepted, temp_spi,
//   entry_index, status from bit 0 up in rsp_tdata.
// csr_ port: index 0 refresh_period, index 1 idle_limit; write only while idle.
// Each entry lives in its own cell; every cell compares the request in
// parallel and a priority pick selects the lowest matching index.
// Lookup and write-back run in the cycle after accept (S_LOOK), the result is
// registered at its end and rsp_tvalid rises in S_OUT. One request in flight,
// so a new request is taken only after the last result has been taken.
// Reset clears every entry and loads the register defaults.
// When rsp_tready is low the result holds and no new request is taken.
module esp_spi_mapping_table #(
   parameter int ENTRIES = espmt_pkg::ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,          // action
   input  logic [103:0] req_tdata,         // header_present, spi, src_ip, dst_ip, priv
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,          // accepted, temp_spi, entry_index, status
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);
   localparam int IW = $clog2(ENTRIES + 1);

   espmt_pkg::state_type st_ff, st_in;
   logic [15:0] period_ff;
   logic [3:0]  limit_ff;
   logic        act_ff, hdr_ff, priv_ff;
   logic [31:0] spi_ff, src_ff, dst_ff;
   logic [ENTRIES-1:0] spi_v, addr_v, free_v, win;
   logic s_any, a_any, f_any;
   logic [IW-1:0] s_idx, a_idx, f_idx, w_idx;
   logic [1:0] kind;
   logic use_e;
   logic [2:0] status;
   logic [20:0] res_ff, res_in;
   espmt_pkg::cmd_type cmd;
   espmt_pkg::flag_type fl [ENTRIES];

   assign req_tready = (st_ff == espmt_pkg::S_IDLE);
   assign rsp_tvalid = (st_ff == espmt_pkg::S_OUT);
   assign rsp_tdata = {3'b000, res_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= espmt_pkg::REFRESH_RST;
         limit_ff <= espmt_pkg::IDLE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            espmt_pkg::CSR_REFRESH: period_ff <= csr_wdata;
            espmt_pkg::CSR_IDLE: limit_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff <= req_tuser;
         hdr_ff <= req_tdata[0];
         spi_ff <= req_tdata[32:1];
         src_ff <= req_tdata[64:33];
         dst_ff <= req_tdata[96:65];
         priv_ff <= req_tdata[97];
      end
   end

   always_comb begin
      cmd.tick = (st_ff == espmt_pkg::S_LOOK) && act_ff;
      cmd.commit = (st_ff == espmt_pkg::S_LOOK) && !act_ff && hdr_ff && use_e;
      cmd.spi = spi_ff;
      cmd.src = src_ff;
      cmd.dst = dst_ff;
      cmd.priv = priv_ff;
      cmd.period = period_ff;
      cmd.limit = limit_ff;
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      espmt_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .win(win[g]), .win_kind(kind), .flags(fl[g])
      );
      assign spi_v[g] = fl[g].spi_hit;
      assign addr_v[g] = fl[g].addr_hit;
      assign free_v[g] = fl[g].free;
      assign win[g] = (w_idx == IW'(g));
   end

   espmt_prio #(.N(ENTRIES)) u_ps (.req(spi_v), .any(s_any), .idx(s_idx));
   espmt_prio #(.N(ENTRIES)) u_pa (.req(addr_v), .any(a_any), .idx(a_idx));
   espmt_prio #(.N(ENTRIES)) u_pf (.req(free_v), .any(f_any), .idx(f_idx));

   // choose the winning entry and status
   always_comb begin
      use_e = 1'b0;
      kind = espmt_pkg::KIND_NEW;
      w_idx = f_idx;
      status = espmt_pkg::ST_FULL;
      priority if (s_any) begin
         use_e = 1'b1; kind = espmt_pkg::KIND_SPI; w_idx = s_idx;
         status = espmt_pkg::ST_SPI_HIT;
      end else if (a_any) begin
         use_e = 1'b1; kind = espmt_pkg::KIND_ADDR; w_idx = a_idx;
         status = espmt_pkg::ST_ADDR_HIT;
      end else if (!priv_ff) begin
         status = espmt_pkg::ST_DENIED;
      end else if (f_any) begin
         use_e = 1'b1; status = espmt_pkg::ST_NEW;
      end
   end

   // result word
   always_comb begin
      res_in = '0;
      if (act_ff) begin
         res_in[20:18] = espmt_pkg::ST_TICK;
      end else if (!hdr_ff) begin
         res_in[0] = 1'b1;
         res_in[20:18] = espmt_pkg::ST_NO_HDR;
      end else begin
         res_in[20:18] = status;
         if (use_e) begin
            res_in[0] = 1'b1;
            res_in[11:1] = 11'(w_idx) + espmt_pkg::TEMP_SPI_BASE;
            res_in[17:12] = 6'(w_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == espmt_pkg::S_LOOK) res_ff <= res_in;
   end

   // sequencer
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         espmt_pkg::S_IDLE: if (req_tvalid) st_in = espmt_pkg::S_LOOK;
         espmt_pkg::S_LOOK: st_in = espmt_pkg::S_OUT;
         espmt_pkg::S_OUT: if (rsp_tready) st_in = espmt_pkg::S_IDLE;
         default: st_in = espmt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= espmt_pkg::S_IDLE;
      else st_ff <= st_in;
   end
endmodule

// ===== rtl/espmt_checker.sv =====
`timescale 1ns / 1ps
module espmt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   // no new request while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while result pending");
   // accept leads to a result after the lookup state
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ##1 rsp_tvalid) else $error("latency");
   // a tick result never claims an entry
   a_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[20:18] == espmt_pkg::ST_TICK) |-> rsp_tdata[17:0] == 18'd0)
      else $error("tick with entry");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule

bind esp_spi_mapping_table espmt_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
   localparam int NENT = 48;
   localparam longint CYCLE_LIMIT = 400000;

   // packed result beat, highest field first
   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  entry_index;
      logic [10:0] temp_spi;
      logic        accepted;
   } flow_result_type;

   // flow table predictor plus queue of pending expected results
   class flow_table_board;
      logic        valid[NENT];
      logic [31:0] lspi[NENT], rspi[NENT], laddr[NENT], raddr[NENT];
      logic        seen[NENT];
      logic [3:0]  idle[NENT];
      logic [15:0] cnt[NENT];
      logic [15:0] period;
      logic [3:0]  limit;
      flow_result_type pending[$];
      int errors, checked, status_seen[7];

      function void clear_all();
         for (int i = 0; i < NENT; i++) wipe(i);
         period = espmt_pkg::REFRESH_RST;
         limit = espmt_pkg::IDLE_RST;
      endfunction

      function void wipe(int i);
         valid[i] = 0; lspi[i] = 0; rspi[i] = 0; laddr[i] = 0; raddr[i] = 0;
         seen[i] = 0; idle[i] = 0; cnt[i] = 0;
      endfunction

      function void age_entries();
         for (int i = 0; i < NENT; i++) begin
            if (!valid[i]) continue;
            if (cnt[i] > 1) begin
               cnt[i]--;
               continue;
            end
            if (seen[i]) begin
               seen[i] = 0;
               idle[i] = 0;
            end else begin
               if (idle[i] != 4'hf) idle[i]++;
               if (idle[i] >= limit) begin
                  wipe(i);
                  continue;
               end
            end
            cnt[i] = period;
         end
      endfunction

      // note an accepted request and queue its expected result
      function void note_request(logic act, logic hdr, logic [31:0] spi,
                                 logic [31:0] src, logic [31:0] dst, logic priv);
         flow_result_type r;
         int idx;
         r = '0;
         idx = -1;
         if (act) begin
            age_entries();
            r.status = espmt_pkg::ST_TICK;
         end else if (!hdr) begin
            r.accepted = 1;
            r.status = espmt_pkg::ST_NO_HDR;
         end else begin
            r.status = espmt_pkg::ST_SPI_HIT;
            for (int i = 0; i < NENT && idx < 0; i++)
               if (valid[i] && (spi == lspi[i] || spi == rspi[i])) begin
                  if (spi == lspi[i] && src == raddr[i]) rspi[i] = spi;
                  idx = i;
               end
            if (idx < 0) begin
               r.status = espmt_pkg::ST_ADDR_HIT;
               for (int i = 0; i < NENT && idx < 0; i++) begin
                  if (!valid[i]) continue;
                  if (src == laddr[i] && priv) begin
                     lspi[i] = spi;
                     if (dst != raddr[i]) begin
                        raddr[i] = dst;
                        rspi[i] = 0;
                     end
                     idx = i;
                  end else if (src == raddr[i] && rspi[i] == 0) begin
                     rspi[i] = spi;
                     idx = i;
                  end
               end
            end
            if (idx < 0) begin
               if (!priv) r.status = espmt_pkg::ST_DENIED;
               else begin
                  for (int i = 0; i < NENT && idx < 0; i++)
                     if (!valid[i]) idx = i;
                  if (idx < 0) r.status = espmt_pkg::ST_FULL;
                  else begin
                     wipe(idx);
                     valid[idx] = 1;
                     cnt[idx] = period;
                     lspi[idx] = spi;
                     laddr[idx] = src;
                     raddr[idx] = dst;
                     r.status = espmt_pkg::ST_NEW;
                  end
               end
            end
            if (idx >= 0) begin
               seen[idx] = 1;
               r.accepted = 1;
               r.temp_spi = 11'(idx) + espmt_pkg::TEMP_SPI_BASE;
               r.entry_index = 6'(idx);
            end
         end
         pending.push_back(r);
      endfunction

      function void check_result(flow_result_type got);
         flow_result_type want;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %h", got);
            return;
         end
         want = pending.pop_front();
         status_seen[want.status]++;
         if (got.accepted !== want.accepted || got.temp_spi !== want.temp_spi ||
             got.entry_index !== want.entry_index || got.status !== want.status) begin
            errors++;
            if (errors <= 10)
               $display("mismatch beat %0d: exp acc=%0d tspi=%0d idx=%0d st=%0d,",
                        checked, want.accepted, want.temp_spi, want.entry_index,
                        want.status, " got acc=%0d tspi=%0d idx=%0d st=%0d",
                        got.accepted, got.temp_spi, got.entry_index, got.status);
         end
      endfunction
   endclass

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tuser;
   logic [103:0] req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [23:0]  rsp_tdata;
   logic         csr_we, csr_addr;
   logic [15:0]  csr_wdata;
   longint       cycles;
   int           sent;
   bit           stim_done;
   flow_table_board board;
   logic [31:0]  addr_pool[8];
   logic [31:0]  spi_pool[8];

   esp_spi_mapping_table uut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("FAILURE");
         $finish;
      end
   end

   // result side: per-beat random wait, check every accepted beat
   initial begin
      int w;
      rsp_tready = 0;
      w = $urandom_range(0, 7);
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(flow_result_type'(rsp_tdata[20:0]));
            rsp_tready <= 0;
            w = $urandom_range(0, 7);
            if ((cycles / 2000) % 3 == 1) w = 0;
         end else if (rsp_tvalid && !rsp_tready) begin
            if (w == 0) rsp_tready <= 1;
            else w--;
         end
      end
   end

   task automatic send_item(logic act, logic hdr, logic [31:0] spi,
                            logic [31:0] src, logic [31:0] dst, logic priv);
      int gap;
      gap = ((sent / 100) % 3 == 2) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= act;
      req_tdata <= {7'd0, priv, dst, src, spi, hdr};
      do @(posedge clock); while (!req_tready);
      board.note_request(act, hdr, spi, src, dst, priv);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == espmt_pkg::CSR_REFRESH) board.period = val;
      else board.limit = val[3:0];
      @(posedge clock);
   endtask

   task automatic random_packet();
      logic [31:0] spi, src, dst;
      int k;
      k = $urandom_range(0, 9);
      spi = (k < 7) ? spi_pool[$urandom_range(0, 7)] : $urandom;
      src = (k < 8) ? addr_pool[$urandom_range(0, 7)] : $urandom;
      dst = (k < 8) ? addr_pool[$urandom_range(0, 7)] : $urandom;
      if ($urandom_range(0, 40) == 0) spi = 0;
      send_item(1'b0, $urandom_range(0, 15) != 0, spi, src, dst,
                $urandom_range(0, 2) != 0);
   endtask

   initial begin
      board = new();
      board.clear_all();
      cycles = 0; sent = 0; stim_done = 0;
      reset <= 1; req_tvalid <= 0; req_tuser <= 0; req_tdata <= '0;
      csr_we <= 0; csr_addr <= 0; csr_wdata <= 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every status, spi 0 against zero remote spi
      write_csr(espmt_pkg::CSR_REFRESH, 16'd2);
      write_csr(espmt_pkg::CSR_IDLE, 16'd1);
      send_item(1'b0, 1'b0, '1, '1, '1, 1'b1);
      send_item(1'b0, 1'b1, 32'h0, 32'h0, 32'h0, 1'b0);
      send_item(1'b0, 1'b1, '1, '1, '1, 1'b1);
      send_item(1'b0, 1'b1, 32'h0, 32'h5, 32'h6, 1'b0);
      send_item(1'b0, 1'b1, 32'h77, '1, 32'h9, 1'b1);
      send_item(1'b0, 1'b1, '1, '1, 32'h1, 1'b0);
      send_item(1'b0, 1'b1, 32'hAA, 32'h1, 32'h3, 1'b0);
      send_item(1'b0, 1'b1, 32'h55, 32'h1, 32'h3, 1'b0);
      send_item(1'b0, 1'b1, 32'h1234, '1, '1, 1'b1);
      for (int i = 0; i < 6; i++) send_item(1'b1, 1'b1, '1, '1, '1, 1'b1);
      drain();
      // fill the table to reach the full case
      write_csr(espmt_pkg::CSR_REFRESH, 16'hffff);
      write_csr(espmt_pkg::CSR_IDLE, 16'd15);
      for (int i = 0; i < NENT + 1; i++)
         send_item(1'b0, 1'b1, 32'h1000 + i, 32'h2000 + i, 32'h3000 + i, 1'b1);
      drain();
      write_csr(espmt_pkg::CSR_REFRESH, 16'd0);
      write_csr(espmt_pkg::CSR_IDLE, 16'd0);
      send_item(1'b1, 1'b0, 0, 0, 0, 1'b0);
      send_item(1'b1, 1'b1, 0, 0, 0, 1'b0);
      drain();

      // random phases with varied settings
      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 8; i++) begin
            addr_pool[i] = (ph % 2) ? $urandom : 32'hC0A80000 + $urandom_range(0, 7);
            spi_pool[i] = (ph % 2) ? $urandom : $urandom_range(0, 9);
         end
         write_csr(espmt_pkg::CSR_REFRESH,
                   (ph == 5) ? 16'hffff : 16'($urandom_range(1, 4)));
         write_csr(espmt_pkg::CSR_IDLE, (ph == 4) ? 16'd15 : 16'($urandom_range(1, 15)));
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 4) == 0) send_item(1'b1, 1'($urandom), $urandom,
                                                     $urandom, $urandom, 1'($urandom));
            else random_packet();
         end
         drain();
      end
      stim_done = 1;
   end

   // end of run
   initial begin
      wait (stim_done);
      $display("%0d requests sent, %0d results checked over six setting phases", sent,
               board.checked);
      $display("status counts: spi %0d addr %0d new %0d nohdr %0d",
               board.status_seen[0], board.status_seen[1], board.status_seen[2],
               board.status_seen[3], " denied %0d full %0d tick %0d",
               board.status_seen[4], board.status_seen[5], board.status_seen[6]);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
